[sv/rnpc_pkg.sv]
// shared types and constants of the radio node poll controller
// no dependencies; used by every module of the block
`default_nettype none

package rnpc_pkg;

  localparam int TICK_W      = 32;
  localparam int STAT_W      = 8;
  localparam int CNT_W       = 3;
  localparam int RET_W       = 2;
  localparam int OUT_IDX_W   = 2;
  localparam int PIPE_W      = 3;
  localparam int MAX_RETRIES = 3;

  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 16;

  // radio status byte
  localparam int ST_RX_BIT   = 6;
  localparam int ST_TX_BIT   = 5;
  localparam int ST_MAX_BIT  = 4;
  localparam int ST_PIPE_LSB = 1;

  localparam logic [CNT_W-1:0]  NODE_COUNT_RST = 3'd1;
  localparam logic [TICK_W-1:0] TX_TIMEOUT_RST = 32'd100;
  localparam logic [TICK_W-1:0] RX_TIMEOUT_RST = 32'd1000;
  localparam logic [TICK_W-1:0] TX_EARLY_RST   = 32'd75;
  localparam logic [TICK_W-1:0] RX_EARLY_RST   = 32'd750;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_TX    = 3'd1,
    PH_WAIT  = 3'd2,
    PH_READY = 3'd3,
    PH_ERROR = 3'd4
  } node_phase_t;

  typedef enum logic [2:0] {
    APP_IDLE    = 3'd0,
    APP_WAIT_TX = 3'd1,
    APP_WAIT_RX = 3'd2,
    APP_DATA    = 3'd3,
    APP_RECOVER = 3'd4
  } app_phase_t;

  typedef enum logic [1:0] {
    REG_NODE_COUNT = 2'd0,
    REG_TX_TIMEOUT = 2'd1,
    REG_RX_TIMEOUT = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [CNT_W-1:0]  eff_count;
    logic [TICK_W-1:0] tx_timeout;
    logic [TICK_W-1:0] rx_timeout;
    logic [TICK_W-1:0] tx_early;
    logic [TICK_W-1:0] rx_early;
  } cfg_t;

  typedef struct packed {
    logic [TICK_W-1:0] poll_tick;
    logic              irq_seen;
    logic              request_measure;
    logic [STAT_W-1:0] radio_status;
  } item_t;

  typedef struct packed {
    logic                 send_request;
    logic [OUT_IDX_W-1:0] request_node;
    logic                 enter_receive;
    logic                 reinit_radio;
    logic                 report_valid;
    logic [OUT_IDX_W-1:0] report_node;
    app_phase_t           app_phase;
    logic [OUT_IDX_W-1:0] active_index;
    logic                 latest_valid;
    logic [OUT_IDX_W-1:0] latest_node;
  } res_t;

endpackage

`default_nettype wire

[sv/rnpc_cfg.sv]
// configuration registers with apb-style access
// keeps raw node count and timeouts, precomputes clamped count and early-poll thresholds
// depends on rnpc_pkg
`default_nettype none

module rnpc_cfg #(
  parameter int MAX_NODES = 4
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_psel,
  input  wire logic                               cfg_penable,
  input  wire logic                               cfg_pwrite,
  input  wire logic [rnpc_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  wire logic [rnpc_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic      [rnpc_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                                    cfg_pready,
  output rnpc_pkg::cfg_t                          cfg
);
  import rnpc_pkg::*;

  logic [CNT_W-1:0]  node_count_r, node_count_nxt;
  logic [CNT_W-1:0]  eff_count_r, eff_count_nxt;
  logic [TICK_W-1:0] tx_timeout_r, tx_timeout_nxt;
  logic [TICK_W-1:0] rx_timeout_r, rx_timeout_nxt;
  logic [TICK_W-1:0] tx_early_r, tx_early_nxt;
  logic [TICK_W-1:0] rx_early_r, rx_early_nxt;
  logic [TICK_W+1:0] three_sum;
  logic [CNT_W-1:0]  wr_count;
  logic              wr_en;
  reg_idx_t          reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = reg_idx_t'(cfg_paddr[3:2]);
  assign wr_count   = cfg_pwdata[CNT_W-1:0];

  // exact 3t/4 rounded down, no wrap
  assign three_sum = {2'b00, cfg_pwdata} + {1'b0, cfg_pwdata, 1'b0};

  always_comb begin
    node_count_nxt = node_count_r;
    eff_count_nxt  = eff_count_r;
    tx_timeout_nxt = tx_timeout_r;
    rx_timeout_nxt = rx_timeout_r;
    tx_early_nxt   = tx_early_r;
    rx_early_nxt   = rx_early_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_NODE_COUNT: begin
          node_count_nxt = wr_count;
          if (wr_count == '0) begin
            eff_count_nxt = CNT_W'(1);
          end else if (wr_count > CNT_W'(MAX_NODES)) begin
            eff_count_nxt = CNT_W'(MAX_NODES);
          end else begin
            eff_count_nxt = wr_count;
          end
        end
        REG_TX_TIMEOUT: begin
          tx_timeout_nxt = cfg_pwdata;
          tx_early_nxt   = three_sum[TICK_W+1:2];
        end
        REG_RX_TIMEOUT: begin
          rx_timeout_nxt = cfg_pwdata;
          rx_early_nxt   = three_sum[TICK_W+1:2];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RST;
      eff_count_r  <= NODE_COUNT_RST;
      tx_timeout_r <= TX_TIMEOUT_RST;
      rx_timeout_r <= RX_TIMEOUT_RST;
      tx_early_r   <= TX_EARLY_RST;
      rx_early_r   <= RX_EARLY_RST;
    end else begin
      node_count_r <= node_count_nxt;
      eff_count_r  <= eff_count_nxt;
      tx_timeout_r <= tx_timeout_nxt;
      rx_timeout_r <= rx_timeout_nxt;
      tx_early_r   <= tx_early_nxt;
      rx_early_r   <= rx_early_nxt;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_NODE_COUNT: cfg_prdata = CFG_DATA_W'(node_count_r);
      REG_TX_TIMEOUT: cfg_prdata = tx_timeout_r;
      REG_RX_TIMEOUT: cfg_prdata = rx_timeout_r;
      default:        cfg_prdata = '0;
    endcase
  end

  assign cfg.eff_count  = eff_count_r;
  assign cfg.tx_timeout = tx_timeout_r;
  assign cfg.rx_timeout = rx_timeout_r;
  assign cfg.tx_early   = tx_early_r;
  assign cfg.rx_early   = rx_early_r;

endmodule

`default_nettype wire

[sv/rnpc_core.sv]
// per-node poll state and the single-pass update for one poll request
// state registers change only when step_en is high or on reset
// depends on rnpc_pkg
`default_nettype none

module rnpc_core #(
  parameter int MAX_NODES = 4
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           step_en,
  input  rnpc_pkg::item_t     item,
  input  rnpc_pkg::cfg_t      cfg,
  output rnpc_pkg::res_t      res
);
  import rnpc_pkg::*;

  localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  node_phase_t       ph_r   [MAX_NODES];
  node_phase_t       ph_nxt [MAX_NODES];
  logic              pend_r   [MAX_NODES];
  logic              pend_nxt [MAX_NODES];
  logic [RET_W-1:0]  ret_r   [MAX_NODES];
  logic [RET_W-1:0]  ret_nxt [MAX_NODES];
  logic [TICK_W-1:0] ss_r   [MAX_NODES];
  logic [TICK_W-1:0] ss_nxt [MAX_NODES];
  logic [TICK_W-1:0] rs_r   [MAX_NODES];
  logic [TICK_W-1:0] rs_nxt [MAX_NODES];

  logic [IDX_W-1:0]  cur_r, cur_nxt;
  app_phase_t        mp_r, mp_nxt;
  logic              irqp_r, irqp_nxt;
  logic              hl_r, hl_nxt;
  logic [IDX_W-1:0]  li_r, li_nxt;

  logic [IDX_W-1:0]  a_v;
  logic [IDX_W-1:0]  next_v;
  logic [CNT_W-1:0]  a_inc;
  logic [TICK_W-1:0] el_tx;
  logic [TICK_W-1:0] el_rx;
  logic [PIPE_W-1:0] pipe_v;
  logic [PIPE_W-1:0] pipe_m1;
  logic [IDX_W-1:0]  k_v;
  logic [RET_W:0]    ret_inc;
  logic              poll_v;
  logic              done_v;
  logic              fail_v;
  logic              rs_hit;
  logic [TICK_W-1:0] now;
  logic [STAT_W-1:0] st;

  assign now     = item.poll_tick;
  assign st      = item.radio_status;
  assign a_v     = (CNT_W'(cur_r) >= cfg.eff_count) ? '0 : cur_r;
  assign a_inc   = CNT_W'(a_v) + CNT_W'(1);
  assign next_v  = (cfg.eff_count <= CNT_W'(1)) ? a_v :
                   (a_inc >= cfg.eff_count) ? '0 : IDX_W'(a_inc);
  assign el_tx   = now - ss_r[a_v];
  assign el_rx   = now - rs_r[a_v];
  assign pipe_v  = st[ST_PIPE_LSB +: PIPE_W];
  assign pipe_m1 = pipe_v - PIPE_W'(1);
  assign k_v     = IDX_W'(pipe_m1);

  always_comb begin
    ph_nxt   = ph_r;
    pend_nxt = pend_r;
    ret_nxt  = ret_r;
    ss_nxt   = ss_r;
    rs_nxt   = rs_r;
    cur_nxt  = cur_r;
    mp_nxt   = mp_r;
    irqp_nxt = irqp_r | item.irq_seen;
    hl_nxt   = hl_r;
    li_nxt   = li_r;
    res      = '0;
    poll_v   = 1'b0;
    done_v   = 1'b0;
    fail_v   = 1'b0;
    rs_hit   = 1'b0;
    ret_inc  = '0;

    if (item.request_measure) begin
      pend_nxt[a_v] = 1'b1;
      mp_nxt        = APP_IDLE;
      cur_nxt       = a_v;
    end

    if (mp_nxt == APP_RECOVER) begin
      // recovery poll: only the re-init, active node is not touched
      res.reinit_radio = 1'b1;
      mp_nxt           = APP_IDLE;
    end else begin
      cur_nxt = a_v;

      // early poll at three quarters of the running timeout
      poll_v = (ph_r[a_v] == PH_TX   && el_tx > cfg.tx_early) ||
               (ph_r[a_v] == PH_WAIT && el_rx > cfg.rx_early);
      if (!irqp_nxt && poll_v &&
          (st[ST_RX_BIT] || st[ST_TX_BIT] || st[ST_MAX_BIT])) begin
        irqp_nxt = 1'b1;
      end

      if (irqp_nxt) begin
        irqp_nxt = 1'b0;
        if (st[ST_RX_BIT] && pipe_v != '0 && CNT_W'(pipe_m1) < cfg.eff_count) begin
          ph_nxt[k_v]  = PH_READY;
          ret_nxt[k_v] = '0;
          hl_nxt       = 1'b1;
          li_nxt       = k_v;
        end
        if (st[ST_TX_BIT] && ph_nxt[a_v] == PH_TX) begin
          rs_nxt[a_v] = now;
          ph_nxt[a_v] = PH_WAIT;
          rs_hit      = 1'b1;
        end
        if (st[ST_MAX_BIT] && ph_nxt[a_v] == PH_TX) begin
          ph_nxt[a_v] = PH_ERROR;
        end
      end

      if (mp_nxt == APP_WAIT_TX && ph_nxt[a_v] == PH_WAIT) begin
        res.enter_receive = 1'b1;
        mp_nxt            = APP_WAIT_RX;
        done_v            = 1'b1;
      end else if (mp_nxt == APP_WAIT_TX && ph_nxt[a_v] == PH_ERROR) begin
        res.enter_receive = 1'b1;
        fail_v            = 1'b1;
        done_v            = 1'b1;
      end

      // a timed-out transmit with a result in status was already taken by the early poll
      if (!done_v && ph_nxt[a_v] == PH_TX && el_tx > cfg.tx_timeout) begin
        ph_nxt[a_v]       = PH_ERROR;
        res.enter_receive = 1'b1;
        fail_v            = 1'b1;
        done_v            = 1'b1;
      end

      if (!done_v && pend_nxt[a_v]) begin
        pend_nxt[a_v] = 1'b0;
        if (ph_nxt[a_v] != PH_TX && ph_nxt[a_v] != PH_WAIT) begin
          res.send_request = 1'b1;
          res.request_node = OUT_IDX_W'(CNT_W'(a_v));
          irqp_nxt         = 1'b0;
          ss_nxt[a_v]      = now;
          rs_nxt[a_v]      = '0;
          ph_nxt[a_v]      = PH_TX;
        end
        mp_nxt = APP_WAIT_TX;
      end

      // reply start just taken from this poll means zero elapsed
      if (!done_v && ph_nxt[a_v] == PH_WAIT && !rs_hit && el_rx > cfg.rx_timeout) begin
        ph_nxt[a_v]       = PH_ERROR;
        res.enter_receive = 1'b1;
        fail_v            = 1'b1;
        done_v            = 1'b1;
      end

      if (!done_v && ph_nxt[a_v] == PH_READY) begin
        ret_nxt[a_v]     = '0;
        ph_nxt[a_v]      = PH_IDLE;
        res.report_valid = 1'b1;
        res.report_node  = OUT_IDX_W'(CNT_W'(a_v));
        cur_nxt          = next_v;
        mp_nxt           = APP_DATA;
      end

      if (fail_v) begin
        ret_inc = {1'b0, ret_nxt[a_v]} + (RET_W+1)'(1);
        if (ret_inc < (RET_W+1)'(MAX_RETRIES)) begin
          ret_nxt[a_v]  = RET_W'(ret_inc);
          pend_nxt[a_v] = 1'b1;
          ph_nxt[a_v]   = PH_IDLE;
          mp_nxt        = APP_IDLE;
        end else begin
          ret_nxt[a_v] = '0;
          cur_nxt      = next_v;
          mp_nxt       = APP_RECOVER;
        end
      end
    end

    res.app_phase    = mp_nxt;
    res.active_index = (CNT_W'(cur_nxt) >= cfg.eff_count) ? '0 :
                       OUT_IDX_W'(CNT_W'(cur_nxt));
    res.latest_valid = hl_nxt;
    res.latest_node  = OUT_IDX_W'(CNT_W'(li_nxt));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_NODES; i++) begin
        ph_r[i]   <= PH_IDLE;
        pend_r[i] <= 1'b0;
        ret_r[i]  <= '0;
      end
      cur_r  <= '0;
      mp_r   <= APP_IDLE;
      irqp_r <= 1'b0;
      hl_r   <= 1'b0;
      li_r   <= '0;
    end else if (step_en) begin
      ph_r   <= ph_nxt;
      pend_r <= pend_nxt;
      ret_r  <= ret_nxt;
      cur_r  <= cur_nxt;
      mp_r   <= mp_nxt;
      irqp_r <= irqp_nxt;
      hl_r   <= hl_nxt;
      li_r   <= li_nxt;
    end
  end

  // start ticks are read only after the phase that sets them
  always_ff @(posedge clk) begin
    if (step_en) begin
      ss_r <= ss_nxt;
      rs_r <= rs_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/radio_node_poll_controller.sv]
// radio node poll controller: one poll request in, one result request out
// result: the request is held in the input register, then its result in the result register
// throughput: one request per cycle unless the output stalls; the per-node state loop closes
// through the single-pass update logic in rnpc_core
// reset: rst_n synchronous active low; node state, config and valid flags return to defaults
// at once, no clearing pass; start ticks and data registers keep their values
`default_nettype none

module radio_node_poll_controller #(
  parameter int MAX_NODES = 4
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // poll_tick[31:0], irq_seen[32], request_measure[33], radio_status[41:34], zero[47:42]
  input  wire logic [rnpc_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // send_request[0], request_node[2:1], enter_receive[3], reinit_radio[4],
  // report_valid[5], report_node[7:6], app_phase[10:8], active_index[12:11],
  // latest_valid[13], latest_node[15:14]
  output logic      [rnpc_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  input  wire logic                                 cfg_psel,
  input  wire logic                                 cfg_penable,
  input  wire logic                                 cfg_pwrite,
  input  wire logic [rnpc_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  wire logic [rnpc_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic      [rnpc_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                      cfg_pready
);
  import rnpc_pkg::*;

  cfg_t  cfg;
  item_t item_r, item_nxt;
  logic  item_valid_r, item_valid_nxt;
  res_t  res;
  res_t  out_r, out_nxt;
  logic  out_valid_r, out_valid_nxt;
  logic  in_fire;
  logic  adv;

  rnpc_cfg #(
    .MAX_NODES (MAX_NODES)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  rnpc_core #(
    .MAX_NODES (MAX_NODES)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (adv),
    .item    (item_r),
    .cfg     (cfg),
    .res     (res)
  );

  // held request moves on when the result register is free or draining
  assign adv       = item_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !item_valid_r || adv;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    item_nxt                 = item_r;
    item_valid_nxt           = item_valid_r;
    out_nxt                  = out_r;
    out_valid_nxt            = out_valid_r;
    if (in_fire) begin
      item_nxt.poll_tick       = in_tdata[31:0];
      item_nxt.irq_seen        = in_tdata[32];
      item_nxt.request_measure = in_tdata[33];
      item_nxt.radio_status    = in_tdata[41:34];
      item_valid_nxt           = 1'b1;
    end else if (adv) begin
      item_valid_nxt = 1'b0;
    end
    if (adv) begin
      out_nxt       = res;
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    out_r  <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.latest_node, out_r.latest_valid, out_r.active_index,
                       out_r.app_phase, out_r.report_node, out_r.report_valid,
                       out_r.reinit_radio, out_r.enter_receive, out_r.request_node,
                       out_r.send_request};

  a_reinit_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.reinit_radio |->
      !out_r.enter_receive && !out_r.send_request && out_r.app_phase == APP_IDLE)
    else $error("re-init result carries other actions");

  a_report_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.report_valid |-> out_r.app_phase == APP_DATA)
    else $error("report without data phase");

  a_send_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.send_request |->
      out_r.app_phase == APP_WAIT_TX && !out_r.report_valid)
    else $error("send without wait-transmit phase");

  a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid_r && !adv |=> item_valid_r && $stable(item_r))
    else $error("held request lost or changed");

endmodule

`default_nettype wire

[tb/radio_node_poll_controller_tb.sv]
// self-checking testbench for radio_node_poll_controller: stream driver, monitor,
// apb register writes and a per-request predictor of the per-node poll state machine
// depends on rnpc_pkg and the radio_node_poll_controller rtl
module radio_node_poll_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rnpc_pkg::*;

  localparam int NODES = 4;
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_MAX = 10;

  localparam logic [7:0] ST_RX  = 8'h1 << ST_RX_BIT;
  localparam logic [7:0] ST_TX  = 8'h1 << ST_TX_BIT;
  localparam logic [7:0] ST_MAX = 8'h1 << ST_MAX_BIT;

  // transmit outcome codes
  localparam int TX_NONE = 0;
  localparam int TX_OK   = 1;
  localparam int TX_FAIL = 2;

  // first bit of each result field in out_tdata after the first field, which starts at bit 0
  localparam logic [15:0] FIELD_START = 16'b0110_1001_0111_1010;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_paddr = '0;
  logic [CFG_DATA_W-1:0]  cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  radio_node_poll_controller #(.MAX_NODES(NODES)) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // stimulus and scoreboard
  logic [IN_TDATA_W-1:0]  poll_backlog [$];
  logic [OUT_TDATA_W-1:0] awaited_results [$];
  logic        holding = 1'b0;
  int          queued_total = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          mismatch_cnt = 0;
  int          cycles = 0;
  logic [31:0] tick_now = '0;

  // predictor state
  node_phase_t nd_phase [NODES];
  logic        nd_pending [NODES];
  int          nd_retries [NODES];
  logic [31:0] nd_sent_at [NODES];
  logic [31:0] nd_acked_at [NODES];
  int          cur_node;
  app_phase_t  mgr;
  logic        irq_flag;
  logic        have_last;
  int          last_node;
  logic [2:0]  cfg_nodes;
  logic [31:0] cfg_tx_to;
  logic [31:0] cfg_rx_to;
  res_t        poll_res;

  function automatic void reset_model();
    for (int i = 0; i < NODES; i++) begin
      nd_phase[i] = PH_IDLE;
      nd_pending[i] = 1'b0;
      nd_retries[i] = 0;
      nd_sent_at[i] = '0;
      nd_acked_at[i] = '0;
    end
    cur_node = 0;
    mgr = APP_IDLE;
    irq_flag = 1'b0;
    have_last = 1'b0;
    last_node = 0;
    cfg_nodes = NODE_COUNT_RST;
    cfg_tx_to = TX_TIMEOUT_RST;
    cfg_rx_to = RX_TIMEOUT_RST;
  endfunction

  function automatic int node_span();
    if (cfg_nodes == 0) return 1;
    if (cfg_nodes > NODES) return NODES;
    return int'(cfg_nodes);
  endfunction

  // wraps the served node into range before use
  function automatic int served_node();
    if (cur_node >= node_span()) cur_node = 0;
    return cur_node;
  endfunction

  function automatic void step_to_next();
    int n;
    n = node_span();
    if (n <= 1) return;
    cur_node++;
    if (cur_node >= n) cur_node = 0;
  endfunction

  function automatic void retry_or_give_up();
    int a;
    a = served_node();
    nd_retries[a]++;
    if (nd_retries[a] < rnpc_pkg::MAX_RETRIES) begin
      nd_pending[a] = 1'b1;
      nd_phase[a] = PH_IDLE;
      mgr = APP_IDLE;
    end else begin
      nd_retries[a] = 0;
      step_to_next();
      mgr = APP_RECOVER;
    end
  endfunction

  function automatic void take_status(input logic [7:0] st, input logic [31:0] now);
    int a;
    int pipe;
    a = served_node();
    if (st[ST_RX_BIT]) begin
      pipe = int'(st[ST_PIPE_LSB +: PIPE_W]);
      if (pipe >= 1 && pipe - 1 < node_span()) begin
        nd_phase[pipe-1] = PH_READY;
        nd_retries[pipe-1] = 0;
        have_last = 1'b1;
        last_node = pipe - 1;
      end
    end
    if (st[ST_TX_BIT] && nd_phase[a] == PH_TX) begin
      nd_acked_at[a] = now;
      nd_phase[a] = PH_WAIT;
    end
    if (st[ST_MAX_BIT] && nd_phase[a] == PH_TX) nd_phase[a] = PH_ERROR;
  endfunction

  function automatic int tx_result();
    int a;
    a = served_node();
    if (mgr != APP_WAIT_TX) return TX_NONE;
    if (nd_phase[a] == PH_WAIT) return TX_OK;
    if (nd_phase[a] == PH_ERROR) return TX_FAIL;
    return TX_NONE;
  endfunction

  // 1 when a transmit outcome ends the poll
  function automatic logic close_tx();
    int ev;
    ev = tx_result();
    if (ev == TX_NONE) return 1'b0;
    poll_res.enter_receive = 1'b1;
    if (ev == TX_OK) mgr = APP_WAIT_RX;
    else retry_or_give_up();
    return 1'b1;
  endfunction

  function automatic logic tx_overdue(input logic [31:0] now);
    int a;
    a = served_node();
    return nd_phase[a] == PH_TX && (now - nd_sent_at[a]) > cfg_tx_to;
  endfunction

  function automatic logic [31:0] three_q(input logic [31:0] t);
    logic [33:0] x;
    x = {2'b00, t} * 34'd3;
    return x[33:2];
  endfunction

  function automatic void poll_core(input logic [31:0] now, input logic [7:0] st);
    int   a;
    logic early;
    if (mgr == APP_RECOVER) begin
      poll_res.reinit_radio = 1'b1;
      mgr = APP_IDLE;
      return;
    end
    a = served_node();

    // early status poll at three quarters of the running timeout
    if (!irq_flag) begin
      early = 1'b0;
      if (nd_phase[a] == PH_TX && (now - nd_sent_at[a]) > three_q(cfg_tx_to)) early = 1'b1;
      if (nd_phase[a] == PH_WAIT && (now - nd_acked_at[a]) > three_q(cfg_rx_to)) early = 1'b1;
      if (early && (st & (ST_RX | ST_TX | ST_MAX)) != 0) irq_flag = 1'b1;
    end
    if (irq_flag) begin
      irq_flag = 1'b0;
      take_status(st, now);
    end
    if (close_tx()) return;

    // late transmit result: irq stays flagged for the next poll
    if (tx_overdue(now) && (st & (ST_TX | ST_MAX)) != 0) begin
      irq_flag = 1'b1;
      take_status(st, now);
      if (close_tx()) return;
    end

    if (tx_overdue(now)) begin
      nd_phase[a] = PH_ERROR;
      poll_res.enter_receive = 1'b1;
      retry_or_give_up();
      return;
    end

    if (nd_pending[a]) begin
      nd_pending[a] = 1'b0;
      if (nd_phase[a] != PH_TX && nd_phase[a] != PH_WAIT) begin
        poll_res.send_request = 1'b1;
        poll_res.request_node = 2'(a);
        irq_flag = 1'b0;
        nd_sent_at[a] = now;
        nd_acked_at[a] = '0;
        nd_phase[a] = PH_TX;
      end
      mgr = APP_WAIT_TX;
    end

    if (nd_phase[a] == PH_WAIT && (now - nd_acked_at[a]) > cfg_rx_to) begin
      nd_phase[a] = PH_ERROR;
      poll_res.enter_receive = 1'b1;
      retry_or_give_up();
      return;
    end

    if (nd_phase[a] == PH_READY) begin
      nd_retries[a] = 0;
      nd_phase[a] = PH_IDLE;
      poll_res.report_valid = 1'b1;
      poll_res.report_node = 2'(a);
      step_to_next();
      mgr = APP_DATA;
    end
  endfunction

  function automatic logic [OUT_TDATA_W-1:0] poll_outcome(input logic [IN_TDATA_W-1:0] req_word);
    int a;
    poll_res = '0;
    if (req_word[32]) irq_flag = 1'b1;
    if (req_word[33]) begin
      a = served_node();
      nd_pending[a] = 1'b1;
      mgr = APP_IDLE;
    end
    poll_core(req_word[31:0], req_word[41:34]);
    poll_res.app_phase = mgr;
    poll_res.active_index = (cur_node >= node_span()) ? 2'd0 : 2'(cur_node);
    poll_res.latest_valid = have_last;
    poll_res.latest_node = 2'(last_node);
    return {poll_res.latest_node, poll_res.latest_valid, poll_res.active_index,
            poll_res.app_phase, poll_res.report_node, poll_res.report_valid,
            poll_res.reinit_radio, poll_res.enter_receive, poll_res.request_node,
            poll_res.send_request};
  endfunction

  function automatic string field_name(input int k);
    case (k)
      0: return "send_request";
      1: return "request_node";
      2: return "enter_receive";
      3: return "reinit_radio";
      4: return "report_valid";
      5: return "report_node";
      6: return "app_phase";
      7: return "active_index";
      8: return "latest_valid";
      default: return "latest_node";
    endcase
  endfunction

  function automatic void check_result(input logic [OUT_TDATA_W-1:0] got);
    logic [OUT_TDATA_W-1:0] want;
    logic [OUT_TDATA_W-1:0] mask;
    int k;
    int lo;
    int b;
    if (awaited_results.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= REPORT_MAX)
        $display("%0t: result %h arrived with none expected", $time, got);
      return;
    end
    want = awaited_results.pop_front();
    k = 0;
    lo = 0;
    for (b = 1; b <= OUT_TDATA_W; b++) begin
      if (b == OUT_TDATA_W || FIELD_START[b]) begin
        mask = OUT_TDATA_W'(((32'h1 << b) - 1) ^ ((32'h1 << lo) - 1));
        if ((want & mask) != (got & mask)) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX)
            $display("%0t: %s expected %0d got %0d (word %h vs %h)", $time, field_name(k),
                     (want & mask) >> lo, (got & mask) >> lo, want, got);
        end
        k++;
        lo = b;
      end
    end
  endfunction

  // clock and watchdog
  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("radio_node_poll_controller_tb: errors");
      $finish;
    end
  end

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!holding) begin
      if (poll_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tdata <= poll_backlog.pop_front();
        in_tvalid <= 1'b1;
        holding = 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // accept side predicts first so a same-cycle result would still find it
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      awaited_results.push_back(poll_outcome(in_tdata));
      holding = 1'b0;
    end
    if (rst_n && out_tvalid && out_tready) check_result(out_tdata);
  end

  task automatic queue_poll(input logic [31:0] now, input logic irq, input logic req,
                            input logic [7:0] st);
    poll_backlog.push_back({6'b0, st, req, irq, now});
    queued_total++;
  endtask

  function automatic logic [31:0] next_gap(input logic [31:0] lim);
    int r;
    r = $urandom_range(99);
    if (r < 65) return $urandom_range(3);
    if (r < 90) return $urandom_range(lim);
    return lim + $urandom_range(1, 5);
  endfunction

  // request, transmit outcome, optional reply: an exchange with random content
  task automatic add_exchange();
    int         span;
    int         r;
    int         pipe;
    logic       irq;
    logic [7:0] st;
    span = node_span();
    tick_now += next_gap(cfg_tx_to);
    queue_poll(tick_now, $urandom_range(99) < 10, 1'b1,
               ($urandom_range(99) < 10) ? 8'($urandom) : 8'h00);
    repeat ($urandom_range(2)) begin
      tick_now += $urandom_range(3);
      queue_poll(tick_now, 1'b0, 1'b0, 8'h00);
    end
    r = $urandom_range(99);
    st = (r < 70) ? ST_TX : (r < 85) ? ST_MAX : 8'h00;
    irq = $urandom_range(99) < 75;
    tick_now += irq ? 32'($urandom_range(3)) : next_gap(cfg_tx_to);
    queue_poll(tick_now, irq, 1'b0, st);
    if (r < 70 && $urandom_range(99) < 85) begin
      repeat ($urandom_range(2)) begin
        tick_now += $urandom_range(3);
        queue_poll(tick_now, 1'b0, 1'b0, 8'h00);
      end
      pipe = ($urandom_range(99) < 80) ? $urandom_range(span, 1) : $urandom_range(7);
      st = ST_RX | 8'(pipe << ST_PIPE_LSB) | (($urandom_range(99) < 10) ? ST_TX : 8'h00);
      irq = $urandom_range(99) < 75;
      tick_now += irq ? 32'($urandom_range(3)) : next_gap(cfg_rx_to);
      queue_poll(tick_now, irq, 1'b0, st);
    end
    // one quiet poll lets a stored reply or a retry go out
    tick_now += $urandom_range(3);
    queue_poll(tick_now, 1'b0, 1'b0, 8'h00);
  endtask

  task automatic add_noise();
    logic [31:0] now;
    now = ($urandom_range(99) < 30) ? $urandom : tick_now + $urandom_range(50);
    queue_poll(now, $urandom_range(1), $urandom_range(1), 8'($urandom_range(255)));
  endtask

  task automatic fill_random(input int count);
    int target;
    target = queued_total + count;
    while (queued_total < target) begin
      if ($urandom_range(99) < 85) add_exchange();
      else add_noise();
    end
  endtask

  task automatic wait_drained();
    while (poll_backlog.size() != 0 || holding || awaited_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_NODE_COUNT: cfg_nodes = val[2:0];
      REG_TX_TIMEOUT: cfg_tx_to = val;
      default:        cfg_rx_to = val;
    endcase
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // each phase drains halfway so the sender sits out until all results are back
  task automatic run_phase(input logic [2:0] nodes, input logic [31:0] tx_to,
                           input logic [31:0] rx_to, input int idle, input int stall,
                           input int count);
    cfg_write(REG_NODE_COUNT, 32'(nodes));
    cfg_write(REG_TX_TIMEOUT, tx_to);
    cfg_write(REG_RX_TIMEOUT, rx_to);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    tick_now = ($urandom_range(3) == 0) ? 32'hFFFF_FFC0 : $urandom;
    fill_random(count / 2);
    wait_drained();
    fill_random(count - count / 2);
    wait_drained();
  endtask

  initial begin
    reset_model();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset defaults: one node, tx timeout 100, rx timeout 1000
    queue_poll(32'd0, 1'b0, 1'b1, 8'h00);
    queue_poll(32'd1, 1'b1, 1'b0, ST_MAX);
    queue_poll(32'd2, 1'b0, 1'b0, 8'h00);
    queue_poll(32'd3, 1'b1, 1'b0, ST_MAX);
    queue_poll(32'd4, 1'b0, 1'b0, 8'h00);
    // third failure leads to recovery, skipped by the request that follows
    queue_poll(32'd5, 1'b1, 1'b0, ST_MAX);
    queue_poll(32'd6, 1'b0, 1'b1, 8'h00);
    queue_poll(32'd7, 1'b1, 1'b0, ST_TX);
    // data on pipe 0, on pipe 5 and on pipe 2 is not for any served node
    queue_poll(32'd8, 1'b1, 1'b0, ST_RX);
    queue_poll(32'd9, 1'b1, 1'b0, ST_RX | 8'h0A);
    queue_poll(32'd10, 1'b1, 1'b0, ST_RX | 8'h04);
    queue_poll(32'd11, 1'b1, 1'b0, ST_RX | 8'h02);
    // transmit timeout, resend, reply timeout
    queue_poll(32'd20, 1'b0, 1'b1, 8'h00);
    queue_poll(32'd200, 1'b0, 1'b0, 8'h00);
    queue_poll(32'd201, 1'b0, 1'b0, 8'h00);
    queue_poll(32'd202, 1'b1, 1'b0, ST_TX);
    queue_poll(32'd2000, 1'b0, 1'b0, 8'h00);
    // tick wrap with every status bit set
    queue_poll(32'hFFFF_FFFF, 1'b1, 1'b1, 8'hFF);
    queue_poll(32'd5, 1'b1, 1'b0, ST_TX);
    queue_poll(32'd16, 1'b1, 1'b0, ST_RX | 8'h02);
    queue_poll(32'd0, 1'b0, 1'b0, 8'hFF);
    tick_now = 32'd100;
    fill_random(150);
    wait_drained();

    run_phase(3'd4, 32'd8, 32'd24, 86, 0, 220);
    run_phase(3'd2, 32'd0, 32'd0, 0, 86, 200);
    run_phase(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 29, 29, 200);
    run_phase(3'd0, 32'd5, 32'd12, 0, 0, 200);
    run_phase(3'd3, 32'd12, 32'd40, 86, 0, 200);
    run_phase(3'd5, 32'd6, 32'd10, 0, 86, 200);
    run_phase(3'd4, 32'd10, 32'd30, 29, 29, 200);
    // lowering the count may leave the served node out of range
    run_phase(3'd1, 32'd3, 32'd7, 0, 0, 120);

    repeat (6) @(posedge clk);
    if (mismatch_cnt == 0 && awaited_results.size() == 0) begin
      $display("radio_node_poll_controller_tb: clean");
    end else begin
      $display("radio_node_poll_controller_tb: errors");
    end
    $finish;
  end

endmodule

[files.f]
sv/rnpc_pkg.sv
sv/rnpc_cfg.sv
sv/rnpc_core.sv
sv/radio_node_poll_controller.sv
tb/radio_node_poll_controller_tb.sv
